[src/clcd_pkg.sv]
package clcd_pkg;

    // Request kinds carried in the input tuser field
    typedef enum logic [2:0] {
        K_INIT   = 3'd0,
        K_CMD    = 3'd1,
        K_DATA   = 3'd2,
        K_CURSOR = 3'd3,
        K_GLYPH  = 3'd4
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CLK_PER_US  = 2'd0,
        CFG_EN_HIGH_US  = 2'd1,
        CFG_SETTLE_US   = 2'd2,
        CFG_CLR_HOME_US = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RAW,
        S_HI,
        S_LO
    } t_state;

    typedef enum logic [1:0] {
        ST_RAW,
        ST_HI,
        ST_LO
    } t_strobe;

    typedef struct packed {
        logic       load;   // latch a new request
        logic       emit;   // write one strobe into the output register
        t_strobe    phase;  // which strobe to build
        logic       init;   // byte comes from the init command list
        logic [1:0] idx;    // init raw nibble or init command index
        logic       last;   // final strobe of the request
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
    } t_dp_sts;

    localparam logic [7:0]  CMD_CLEAR      = 8'h01;
    localparam logic [7:0]  CMD_HOME       = 8'h02;
    localparam logic [7:0]  CMD_SET_CGRAM  = 8'h40;
    localparam logic [7:0]  CMD_SET_DDRAM  = 8'h80;
    localparam logic [15:0] POWER_WAIT_US  = 16'd50000;

    localparam logic [7:0]  ROW_OFS       [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [7:0]  INIT_CMD      [4] = '{8'h28, 8'h0C, 8'h06, 8'h01};
    localparam logic [3:0]  INIT_RAW_NIB  [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [15:0] INIT_RAW_WAIT [4] = '{16'd5000, 16'd1000, 16'd1000, 16'd1000};

endpackage

[src/clcd_ctrl.sv]
module clcd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic [2:0]           i_req_kind,
    output logic                 o_req_ready,
    input  clcd_pkg::t_dp_sts    i_sts,
    output clcd_pkg::t_dp_cmd    o_cmd
);

    clcd_pkg::t_state r_state, n_state;
    logic [1:0]       r_idx, n_idx;
    logic             r_init, n_init;
    logic             w_final;
    logic             w_accept;

    // last byte strobe of a request: any plain byte, or the fourth init command
    assign w_final  = !r_init || (r_idx == 2'd3);
    assign w_accept = i_req_valid && o_req_ready;

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.load  = w_accept;
        o_cmd.init  = r_init;
        o_cmd.idx   = r_idx;
        o_cmd.phase = clcd_pkg::ST_HI;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
            end
            clcd_pkg::S_RAW: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.phase = clcd_pkg::ST_RAW;
            end
            clcd_pkg::S_HI: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.phase = clcd_pkg::ST_HI;
            end
            clcd_pkg::S_LO: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.phase = clcd_pkg::ST_LO;
                o_cmd.last  = w_final;
                o_req_ready = i_sts.out_free && w_final;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_init  = r_init;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
            end
            clcd_pkg::S_RAW: begin
                if (i_sts.out_free) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = clcd_pkg::S_HI;
                        n_init  = 1'b1;
                    end
                end
            end
            clcd_pkg::S_HI: begin
                if (i_sts.out_free) begin
                    n_state = clcd_pkg::S_LO;
                end
            end
            clcd_pkg::S_LO: begin
                if (i_sts.out_free) begin
                    if (w_final) begin
                        n_state = clcd_pkg::S_IDLE;
                        n_init  = 1'b0;
                    end else begin
                        n_state = clcd_pkg::S_HI;
                        n_idx   = r_idx + 2'd1;
                    end
                end
            end
            default: begin
                n_state = clcd_pkg::S_IDLE;
            end
        endcase
        // a new request overrides the return to idle
        if (w_accept) begin
            n_idx  = 2'd0;
            n_init = 1'b0;
            unique case (i_req_kind)
                clcd_pkg::K_INIT:   n_state = clcd_pkg::S_RAW;
                clcd_pkg::K_CMD,
                clcd_pkg::K_DATA,
                clcd_pkg::K_CURSOR,
                clcd_pkg::K_GLYPH:  n_state = clcd_pkg::S_HI;
                default:            n_state = clcd_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clcd_pkg::S_IDLE;
            r_idx   <= 2'd0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_init  <= n_init;
        end
    end

endmodule

[src/clcd_dpath.sv]
module clcd_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic [23:0]        i_req_data,
    input  logic [2:0]         i_req_kind,
    input  clcd_pkg::t_dp_cmd  i_cmd,
    output clcd_pkg::t_dp_sts  o_sts,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [39:0]        o_m_data,
    output logic               o_m_user,
    output logic               o_m_last
);

    logic [9:0]  r_settle;
    logic [15:0] r_clr_home;
    logic [7:0]  r_byte;
    logic        r_rs;
    logic        r_valid;
    logic        r_o_rs;
    logic [3:0]  r_o_nib;
    logic [15:0] r_o_before;
    logic [16:0] r_o_after;
    logic        r_o_last;

    logic [7:0]  w_bv, w_col, w_line;
    logic [1:0]  w_row;
    logic [7:0]  n_byte;
    logic        n_rs;
    logic [7:0]  w_cur_byte;
    logic        w_cur_rs;
    logic [3:0]  w_nib;
    logic [15:0] w_before;
    logic [15:0] w_extra;

    assign w_bv   = i_req_data[7:0];
    assign w_col  = i_req_data[15:8];
    assign w_line = i_req_data[23:16];
    assign w_row  = (w_line > 8'd3) ? 2'd3 : w_line[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle   <= 10'd50;
            r_clr_home <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (clcd_pkg::t_cfg_idx'(i_cfg_addr))
                // timing for the enable stage further down; no strobe depends on it
                clcd_pkg::CFG_CLK_PER_US,
                clcd_pkg::CFG_EN_HIGH_US: begin
                end
                clcd_pkg::CFG_SETTLE_US:   r_settle   <= i_cfg_wdata[9:0];
                clcd_pkg::CFG_CLR_HOME_US: r_clr_home <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // build the request byte once at accept time
    always_comb begin
        n_rs = (i_req_kind == clcd_pkg::K_DATA);
        unique case (i_req_kind)
            clcd_pkg::K_CURSOR: n_byte = clcd_pkg::CMD_SET_DDRAM
                                       | (clcd_pkg::ROW_OFS[w_row] + w_col);
            clcd_pkg::K_GLYPH:  n_byte = clcd_pkg::CMD_SET_CGRAM
                                       | {2'b00, w_bv[2:0], 3'b000};
            default:            n_byte = w_bv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
        end
    end

    assign w_cur_byte = i_cmd.init ? clcd_pkg::INIT_CMD[i_cmd.idx] : r_byte;
    assign w_cur_rs   = i_cmd.init ? 1'b0 : r_rs;

    always_comb begin
        w_nib    = w_cur_byte[7:4];
        w_before = 16'd0;
        w_extra  = 16'd0;
        unique case (i_cmd.phase)
            clcd_pkg::ST_RAW: begin
                w_nib   = clcd_pkg::INIT_RAW_NIB[i_cmd.idx];
                w_extra = clcd_pkg::INIT_RAW_WAIT[i_cmd.idx];
                if (i_cmd.idx == 2'd0) begin
                    w_before = clcd_pkg::POWER_WAIT_US;
                end
            end
            clcd_pkg::ST_HI: begin
                w_nib = w_cur_byte[7:4];
            end
            clcd_pkg::ST_LO: begin
                w_nib = w_cur_byte[3:0];
                if (!w_cur_rs && (w_cur_byte == clcd_pkg::CMD_CLEAR
                               || w_cur_byte == clcd_pkg::CMD_HOME)) begin
                    w_extra = r_clr_home;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.out_free = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_rs     <= (i_cmd.phase == clcd_pkg::ST_RAW) ? 1'b0 : w_cur_rs;
            r_o_nib    <= w_nib;
            r_o_before <= w_before;
            r_o_after  <= {7'd0, r_settle} + {1'b0, w_extra};
            r_o_last   <= i_cmd.last;
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_data  = {3'b000, r_o_after, r_o_before, r_o_nib};
    assign o_m_user  = r_o_rs;
    assign o_m_last  = r_o_last;

endmodule

[src/char_lcd_4bit_sequencer.sv]
// Character LCD 4-bit sequencer: each request word on the slave stream
// (init, command byte, data byte, cursor set or glyph address) becomes a
// run of nibble strobe words on the master stream, high nibble first, the
// final one marked with tlast. Init gives twelve words (raw nibbles 3,3,3,2,
// then commands 0x28, 0x0C, 0x06, 0x01); every other kind gives two; kinds
// 5 to 7 are dropped with no output. Throughput is one strobe word per clock
// while the master side is ready; the single output word register sets that
// pace, and the next request is taken in the cycle the final strobe of the
// current one is written. Configuration writes are only for an idle block.
// Registers 0 (clocks per microsecond) and 1 (enable high time) serve the
// downstream enable timer and do not change any strobe word here.
module char_lcd_4bit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_value[7:0], column[15:8], line[23:16]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    // strobe stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // nibble[3:0], wait_before_us[19:4],
                                        // wait_after_us[36:20], zero fill [39:37]
    output logic        m_axis_tuser,   // register_select
    output logic        m_axis_tlast
);

    clcd_pkg::t_dp_cmd w_cmd;
    clcd_pkg::t_dp_sts w_sts;

    // sequencer: walks the strobe list of the current request
    clcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_kind  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: request byte, wait arithmetic, output word register
    clcd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (s_axis_tdata),
        .i_req_kind  (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser),
        .o_m_last    (m_axis_tlast)
    );

endmodule

[src/clcd_chk.sv]
module clcd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled strobe word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("strobe word changed while stalled");

    // a known request kind closes the slave side in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser <= clcd_pkg::K_GLYPH)
            |=> !s_axis_tready)
        else $error("request taken while previous one still running");

    // the power-up wait only rides on the first init nibble
    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[19:4] != 16'd0) |->
            !m_axis_tuser && (m_axis_tdata[3:0] == 4'h3) && !m_axis_tlast)
        else $error("wait before enable on a non-init strobe");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:37] == 3'b000))
        else $error("nonzero fill bits in strobe word");

endmodule

bind char_lcd_4bit_sequencer clcd_chk u_clcd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
